// ----- sv/wsfp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfp_pkg: shared types for the WebSocket frame parser
// Parse phases and the result word passed from the parser to the top level.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXTHI = 3'd2,
    PH_EXTLO = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  localparam logic [6:0]  LEN_EXT16 = 7'd126;
  localparam logic [6:0]  LEN_EXT64 = 7'd127;
  localparam logic [3:0]  OP_TEXT   = 4'h1;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        has;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        is_text;
    logic        message_end;
    logic [31:0] message_length;
    logic        length_error;
  } result_t;

endpackage

// ----- sv/wsfp_parser.sv -----
// ----------------------------------------------------------------------------
// wsfp_parser: frame header and payload state machine
// Holds the parse state, advances it by one byte when step is high and
// presents the result word that byte causes.
// ----------------------------------------------------------------------------
module wsfp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data,
  output wsfp_pkg::result_t res
);
  import wsfp_pkg::*;

  phase_t      phase, phase_next;
  logic        final_frame, final_frame_next;
  logic        first_frame, first_frame_next;
  logic        text_flag, text_flag_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [31:0] total_count, total_count_next;

  logic [6:0]  len_code;
  logic [15:0] ext_len;
  logic [15:0] left_dec;
  logic [31:0] total_inc;

  assign len_code  = data[6:0];
  assign ext_len   = {length_high, data};
  assign left_dec  = bytes_left - 16'd1;
  assign total_inc = (total_count == COUNT_MAX) ? total_count : total_count + 32'd1;

  // next phase
  always_comb begin
    case (phase)
      PH_HDR1: begin
        if (len_code == LEN_EXT64) phase_next = PH_HDR0;
        else if (len_code == LEN_EXT16) phase_next = PH_EXTHI;
        else if (len_code != 7'd0) phase_next = PH_DATA;
        else phase_next = PH_HDR0;
      end
      PH_EXTHI: phase_next = PH_EXTLO;
      PH_EXTLO: phase_next = (ext_len != 16'd0) ? PH_DATA : PH_HDR0;
      PH_DATA:  phase_next = (left_dec == 16'd0) ? PH_HDR0 : PH_DATA;
      default:  phase_next = PH_HDR1;
    endcase
  end

  // datapath state and result
  always_comb begin
    final_frame_next = final_frame;
    first_frame_next = first_frame;
    text_flag_next   = text_flag;
    length_high_next = length_high;
    bytes_left_next  = bytes_left;
    total_count_next = total_count;
    res              = '0;
    case (phase)
      PH_HDR1: begin
        if (len_code == LEN_EXT64) begin
          res.has          = 1'b1;
          res.length_error = 1'b1;
          final_frame_next = 1'b0;
          first_frame_next = 1'b1;
          text_flag_next   = 1'b0;
          length_high_next = '0;
          bytes_left_next  = '0;
          total_count_next = '0;
        end else if (len_code == LEN_EXT16) begin
          // wait for extended length
        end else if (len_code != 7'd0) begin
          bytes_left_next = {9'd0, len_code};
        end else if (final_frame) begin
          res.has            = 1'b1;
          res.is_text        = text_flag;
          res.message_end    = 1'b1;
          res.message_length = total_count;
          first_frame_next   = 1'b1;
          text_flag_next     = 1'b0;
          total_count_next   = '0;
          final_frame_next   = 1'b0;
        end
      end
      PH_EXTHI: length_high_next = data;
      PH_EXTLO: begin
        if (ext_len != 16'd0) begin
          bytes_left_next = ext_len;
        end else if (final_frame) begin
          res.has            = 1'b1;
          res.is_text        = text_flag;
          res.message_end    = 1'b1;
          res.message_length = total_count;
          first_frame_next   = 1'b1;
          text_flag_next     = 1'b0;
          total_count_next   = '0;
          final_frame_next   = 1'b0;
        end
      end
      PH_DATA: begin
        res.has           = 1'b1;
        res.payload_byte  = data;
        res.payload_valid = 1'b1;
        res.is_text       = text_flag;
        bytes_left_next   = left_dec;
        total_count_next  = total_inc;
        if (left_dec == 16'd0 && final_frame) begin
          res.message_end    = 1'b1;
          res.message_length = total_inc;
          first_frame_next   = 1'b1;
          text_flag_next     = 1'b0;
          total_count_next   = '0;
          final_frame_next   = 1'b0;
        end
      end
      default: begin
        final_frame_next = data[7];
        if (first_frame) begin
          text_flag_next   = (data[3:0] == OP_TEXT);
          first_frame_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      final_frame <= 1'b0;
      first_frame <= 1'b1;
      text_flag   <= 1'b0;
      length_high <= '0;
      bytes_left  <= '0;
      total_count <= '0;
    end else if (step) begin
      phase       <= phase_next;
      final_frame <= final_frame_next;
      first_frame <= first_frame_next;
      text_flag   <= text_flag_next;
      length_high <= length_high_next;
      bytes_left  <= bytes_left_next;
      total_count <= total_count_next;
    end
  end

endmodule

// ----- sv/websocket_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_parser_core: unmasked WebSocket frame parser
// Parses a received byte stream into payload bytes and message ends.
// ----------------------------------------------------------------------------
// Input channel: byte_valid / byte_stall carry one stream word (in_byte) per
// cycle; a word is taken when byte_valid is high and byte_stall is low.
// Output channel: result_valid / result_stall carry one result word with
// payload_byte, payload_valid, is_text, message_end, message_length and
// length_error. Header bytes that end nothing give no result word.
// Path: a taken word passes through the input register, then parser logic into
// the result register.
// Throughput: one word per cycle while no stalled result holds the flow; the
// parser state updates once per taken word.
// Reset (rst, synchronous): clears the valid bits of both registers and returns
// the parser to expecting the first header byte of a new message.
// Stall: while result_stall holds a pending result, the parser holds too; the input
// register holds once it is full, and byte_stall rises then.
// ----------------------------------------------------------------------------
module websocket_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        is_text,
  output logic        message_end,
  output logic [31:0] message_length,
  output logic        length_error
);
  import wsfp_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_open;
  logic       advance;
  result_t    res;

  assign out_open   = !result_valid || !result_stall;
  assign advance    = held_valid && out_open;
  assign byte_stall = held_valid && !out_open;

  wsfp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .data (held_byte),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      held_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_open) begin
      result_valid <= advance && res.has;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      payload_byte   <= res.payload_byte;
      payload_valid  <= res.payload_valid;
      is_text        <= res.is_text;
      message_end    <= res.message_end;
      message_length <= res.message_length;
      length_error   <= res.length_error;
    end
  end

endmodule

// ----- sv/wsfp_checker.sv -----
// ----------------------------------------------------------------------------
// wsfp_checker: port-level checks for the frame parser
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
module wsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  payload_byte,
  input logic        payload_valid,
  input logic        is_text,
  input logic        message_end,
  input logic [31:0] message_length,
  input logic        length_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(payload_byte)
      && $stable(message_length) && $stable(message_end))
    else $error("stalled result word changed");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && length_error |-> !payload_valid && !is_text && !message_end
      && message_length == 32'd0 && payload_byte == 8'd0)
    else $error("error word carries data");

  a_len_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !message_end |-> message_length == 32'd0)
    else $error("length outside message end");

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !payload_valid && !length_error |-> message_end)
    else $error("data-less word that is not a message end");

endmodule

bind websocket_frame_parser_core wsfp_checker u_wsfp_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .payload_byte   (payload_byte),
  .payload_valid  (payload_valid),
  .is_text        (is_text),
  .message_end    (message_end),
  .message_length (message_length),
  .length_error   (length_error)
);
